### rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Types, register indexes, constants and rounding helpers for the rate PID.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

   typedef struct packed {
      logic [1:0]         axis;
      logic signed [15:0] rate_error;
      logic signed [15:0] gyro_rate;
      logic [14:0]        vcomp;
      logic               on_ground;
      logic               airborne;
      logic               flipping;
      logic               level_mode;
      logic               race_mode;
   } req_type;

   typedef struct packed {
      logic [1:0]         out_axis;
      logic signed [15:0] drive;
      logic               windup_held;
   } rsp_type;

   typedef enum logic [2:0] {
      CSR_KP_GAINS    = 3'd0,
      CSR_KI_GAINS    = 3'd1,
      CSR_KD_GAINS    = 3'd2,
      CSR_SP_WEIGHTS  = 3'd3,
      CSR_AXIS_LIMITS = 3'd4,
      CSR_LOOP_DT     = 3'd5,
      CSR_TIME_FACTOR = 3'd6,
      CSR_DTERM_COEFF = 3'd7
   } csr_index_type;

   localparam logic [47:0] SP_WEIGHTS_RESET  = 48'hFFFF_FFFF_FFFF;
   localparam logic [23:0] LOOP_DT_RESET     = 24'd16777;
   localparam logic [15:0] TIME_FACTOR_RESET = 16'd13107;

   // 0.98 and 1/6 in Q0.16
   localparam logic signed [18:0] WIND_K  = 19'sd64225;
   localparam logic signed [18:0] SIXTH_K = 19'sd10923;

   localparam logic signed [66:0] S32_MAX = 67'sd2147483647;
   localparam logic signed [66:0] S32_MIN = -67'sd2147483648;

   // round half up, then arithmetic shift
   function automatic logic signed [66:0] rnd_shift(input logic signed [66:0] v,
                                                    input int unsigned s);
      logic signed [66:0] half;
      half = 67'sd1 <<< (s - 1);
      rnd_shift = (v + half) >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
      logic signed [66:0] t;
      t = v;
      if (v > S32_MAX) t = S32_MAX;
      if (v < S32_MIN) t = S32_MIN;
      sat32 = t[31:0];
   endfunction

   function automatic logic [15:0] field16(input logic [47:0] r, input logic [1:0] ax);
      logic [15:0] f;
      f = 16'd0;
      if (ax != 2'd3) f = r[{ax, 4'b0000} +: 16];
      field16 = f;
   endfunction

endpackage

`default_nettype wire

### rtl/axis_rate_pid_controller_core.sv
// ----------------------------------------------------------------------------
// axis_rate_pid_controller_core
// Three-axis rate PID with anti-windup, one axis per transaction.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one transaction carries the axis, rate error, gyro rate,
//    output scale and flight flags. Accepted when req_valid and !req_stall.
//  - rsp channel: one transaction per accepted request whose axis is below
//    AXES, carrying axis, clamped drive and the windup-hold flag. A request
//    for an axis at or above AXES is dropped with no result.
//  - csr channel: register index and data, always ready; write only while
//    the block is idle.
//  - A new request is taken only once the previous one is through, since
//    the single shared 48x19 multiplier serves all 13 products that the
//    sequencer forms for it.
//  - req_stall is high from accept until the result moves into the output
//    register. If rsp_stall holds a previous result, the sequencer waits in
//    its final step until the output register is free.
//  - Reset (synchronous) clears all per-axis state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_rate_pid_controller_core #(
   parameter int AXES = 3
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire arpc_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output arpc_pkg::rsp_type       rsp_data,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire  [2:0]              csr_index,
   input  wire  [53:0]             csr_data
);

   localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

   // sequencer steps; most form one product of the shared multiplier
   typedef enum logic [15:0] {
      S_IDLE = 16'h0001,
      S_WIND = 16'h0002,   // acc * 0.98
      S_SUM  = 16'h0004,   // Simpson sum * 1/6
      S_INC1 = 16'h0008,   // s1 * dt
      S_INC2 = 16'h0010,   // * ki
      S_PB   = 16'h0020,   // e * b
      S_PG   = 16'h0040,   // g * (1 - b)
      S_PK   = 16'h0080,   // diff * kp
      S_D1   = 16'h0100,   // -dg * kd
      S_D2   = 16'h0200,   // * time factor
      S_F0   = 16'h0400,   // c_in * raw
      S_F1   = 16'h0800,   // c_one * y1
      S_F2   = 16'h1000,   // c_two * y2
      S_FY   = 16'h2000,   // filter output, D into total
      S_VC   = 16'h4000,   // total * vcomp
      S_DONE = 16'h8000    // drive, commit state
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [47:0] kp_ff, ki_ff, kd_ff, sw_ff, lim_ff;
   logic [23:0] dt_ff;
   logic [15:0] tf_ff;
   logic [53:0] dc_ff;

   // per-axis state
   logic signed [31:0] integ_ff  [AXES];
   logic signed [15:0] pe1_ff    [AXES];
   logic signed [15:0] pe2_ff    [AXES];
   logic signed [15:0] pdrive_ff [AXES];
   logic signed [15:0] prate_ff  [AXES];
   logic signed [31:0] fy1_ff    [AXES];
   logic signed [31:0] fy2_ff    [AXES];

   // working registers
   arpc_pkg::req_type  in_ff;
   logic               held_ff;
   logic               wind_ff;
   logic signed [31:0] acc_ff;
   logic signed [66:0] prod_ff;
   logic signed [66:0] t_ff;
   logic signed [47:0] total_ff;
   logic               rsp_valid_ff;
   arpc_pkg::rsp_type  rsp_ff;

   logic [IDX_W-1:0]   idx;
   logic [15:0]        kp, ki, kd, bw, lim_raw;
   logic [14:0]        lim15;
   logic signed [16:0] lim_s;
   logic signed [15:0] e, g;
   logic signed [19:0] sum20;
   logic signed [66:0] s1, inc, p_r, raw_r, y_r, t1, t2;
   logic signed [39:0] acc_sum, limq, acc_cl;
   logic signed [31:0] raw, y;
   logic signed [16:0] dd, pd;
   logic [16:0]        nb;
   logic signed [66:0] lim67, drive67;
   logic               done_go;
   logic               axis_ok;

   logic signed [47:0] mul_a;
   logic signed [18:0] mul_b;
   logic signed [66:0] mul_p;

   assign idx     = in_ff.axis[IDX_W-1:0];
   assign e       = in_ff.rate_error;
   assign g       = in_ff.gyro_rate;
   assign kp      = arpc_pkg::field16(kp_ff, in_ff.axis);
   assign ki      = arpc_pkg::field16(ki_ff, in_ff.axis);
   assign kd      = arpc_pkg::field16(kd_ff, in_ff.axis);
   assign bw      = arpc_pkg::field16(sw_ff, in_ff.axis);
   assign lim_raw = arpc_pkg::field16(lim_ff, in_ff.axis);
   assign lim15   = lim_raw[15] ? 15'h7FFF : lim_raw[14:0];
   assign lim_s   = $signed({2'b00, lim15});
   assign nb      = 17'h10000 - {1'b0, bw};

   assign sum20 = 20'(pe2_ff[idx]) + (20'(pe1_ff[idx]) <<< 2) + 20'(e);
   assign s1    = arpc_pkg::rnd_shift(prod_ff, 16);
   assign inc   = arpc_pkg::rnd_shift(prod_ff, 18);
   assign acc_sum = 40'(acc_ff) + (held_ff ? 40'sd0 : $signed(inc[39:0]));
   assign limq    = $signed({11'b0, lim15, 14'b0});
   always_comb begin
      acc_cl = acc_sum;
      if (acc_sum > limq) acc_cl = limq;
      if (acc_sum < -limq) acc_cl = -limq;
   end

   assign p_r   = arpc_pkg::rnd_shift(prod_ff, 10);
   assign dd    = 17'(prate_ff[idx]) - 17'(g);
   assign raw_r = arpc_pkg::rnd_shift(prod_ff, 18);
   assign raw   = arpc_pkg::sat32(raw_r);
   assign y_r   = arpc_pkg::rnd_shift(t_ff - prod_ff, 16);
   assign y     = arpc_pkg::sat32(y_r);
   assign t1    = arpc_pkg::rnd_shift(prod_ff, 14);
   assign t2    = arpc_pkg::rnd_shift(t1, 14);
   assign lim67 = 67'(lim_s);
   always_comb begin
      drive67 = t2;
      if (t2 > lim67) drive67 = lim67;
      if (t2 < -lim67) drive67 = -lim67;
   end

   assign pd      = 17'(pdrive_ff[idx]);
   assign done_go = !rsp_valid_ff || !rsp_stall;
   assign axis_ok = (32'(req_data.axis) < AXES);

   // shared multiplier operand select
   always_comb begin
      mul_a = 48'sd0;
      mul_b = 19'sd0;
      case (state_ff)
         S_WIND: begin
            mul_a = 48'(integ_ff[idx]);
            mul_b = arpc_pkg::WIND_K;
         end
         S_SUM: begin
            mul_a = 48'(sum20);
            mul_b = arpc_pkg::SIXTH_K;
         end
         S_INC1: begin
            mul_a = $signed({24'b0, dt_ff});
            mul_b = s1[18:0];
         end
         S_INC2: begin
            mul_a = prod_ff[47:0];
            mul_b = $signed({3'b0, ki});
         end
         S_PB: begin
            mul_a = 48'(e);
            mul_b = $signed({3'b0, bw});
         end
         S_PG: begin
            mul_a = 48'(g);
            mul_b = $signed({2'b0, nb});
         end
         S_PK: begin
            mul_a = t_ff[47:0] - prod_ff[47:0];
            mul_b = $signed({3'b0, kp});
         end
         S_D1: begin
            mul_a = 48'(dd);
            mul_b = $signed({3'b0, kd});
         end
         S_D2: begin
            mul_a = prod_ff[47:0];
            mul_b = $signed({3'b0, tf_ff});
         end
         S_F0: begin
            mul_a = 48'(raw);
            mul_b = $signed({1'b0, dc_ff[17:0]});
         end
         S_F1: begin
            mul_a = 48'(fy1_ff[idx]);
            mul_b = $signed({1'b0, dc_ff[35:18]});
         end
         S_F2: begin
            mul_a = 48'(fy2_ff[idx]);
            mul_b = $signed({1'b0, dc_ff[53:36]});
         end
         S_VC: begin
            mul_a = total_ff;
            mul_b = $signed({4'b0, in_ff.vcomp});
         end
         default: begin
            mul_a = 48'sd0;
            mul_b = 19'sd0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid && axis_ok) state_in = S_WIND;
         S_WIND: state_in = S_SUM;
         S_SUM:  state_in = S_INC1;
         S_INC1: state_in = S_INC2;
         S_INC2: state_in = S_PB;
         S_PB:   state_in = S_PG;
         S_PG:   state_in = S_PK;
         S_PK:   state_in = S_D1;
         S_D1:   state_in = S_D2;
         S_D2:   state_in = S_F0;
         S_F0:   state_in = S_F1;
         S_F1:   state_in = S_F2;
         S_F2:   state_in = S_FY;
         S_FY:   state_in = S_VC;
         S_VC:   state_in = S_DONE;
         S_DONE: if (done_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // control, configuration and per-axis state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         kp_ff  <= '0;
         ki_ff  <= '0;
         kd_ff  <= '0;
         sw_ff  <= arpc_pkg::SP_WEIGHTS_RESET;
         lim_ff <= '0;
         dt_ff  <= arpc_pkg::LOOP_DT_RESET;
         tf_ff  <= arpc_pkg::TIME_FACTOR_RESET;
         dc_ff  <= '0;
         for (int i = 0; i < AXES; i++) begin
            integ_ff[i]  <= '0;
            pe1_ff[i]    <= '0;
            pe2_ff[i]    <= '0;
            pdrive_ff[i] <= '0;
            prate_ff[i]  <= '0;
            fy1_ff[i]    <= '0;
            fy2_ff[i]    <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            case (arpc_pkg::csr_index_type'(csr_index))
               arpc_pkg::CSR_KP_GAINS:    kp_ff  <= csr_data[47:0];
               arpc_pkg::CSR_KI_GAINS:    ki_ff  <= csr_data[47:0];
               arpc_pkg::CSR_KD_GAINS:    kd_ff  <= csr_data[47:0];
               arpc_pkg::CSR_SP_WEIGHTS:  sw_ff  <= csr_data[47:0];
               arpc_pkg::CSR_AXIS_LIMITS: lim_ff <= csr_data[47:0];
               arpc_pkg::CSR_LOOP_DT:     dt_ff  <= csr_data[23:0];
               arpc_pkg::CSR_TIME_FACTOR: tf_ff  <= csr_data[15:0];
               arpc_pkg::CSR_DTERM_COEFF: dc_ff  <= csr_data;
               default: ;
            endcase
         end

         // a new result wins over the pop of the old one
         if (state_ff == S_DONE && done_go) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;

         // D path commits its state only for a nonzero gain
         if (state_ff == S_FY && kd != 16'd0) begin
            fy2_ff[idx]   <= fy1_ff[idx];
            fy1_ff[idx]   <= y;
            prate_ff[idx] <= g;
         end

         if (state_ff == S_DONE && done_go) begin
            integ_ff[idx]    <= acc_ff;
            pdrive_ff[idx]   <= drive67[15:0];
            if (!held_ff) begin
               pe2_ff[idx] <= pe1_ff[idx];
               pe1_ff[idx] <= e;
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff != S_DONE) prod_ff <= mul_p;

      case (state_ff)
         S_IDLE: in_ff <= req_data;
         S_WIND: begin
            acc_ff  <= integ_ff[idx];
            wind_ff <= (in_ff.level_mode && !in_ff.race_mode) ?
                       (in_ff.on_ground || !in_ff.airborne || in_ff.flipping) :
                       (in_ff.on_ground || in_ff.flipping);
            held_ff <= ((pd >= lim_s) && (e > 16'sd0)) ||
                       ((pd <= -lim_s) && (e < 16'sd0));
         end
         // prod_ff holds acc * 0.98 here
         S_SUM: if (wind_ff) acc_ff <= s1[31:0];
         S_PB:  acc_ff   <= acc_cl[31:0];
         S_PG:  t_ff     <= prod_ff;
         S_D1:  total_ff <= p_r[47:0] + 48'(acc_ff);
         S_F1:  t_ff     <= prod_ff;
         S_F2:  t_ff     <= t_ff + prod_ff;
         S_FY:  if (kd != 16'd0) total_ff <= total_ff + (48'(y) <<< 12);
         S_DONE: begin
            if (done_go) begin
               rsp_ff.out_axis    <= in_ff.axis;
               rsp_ff.drive       <= drive67[15:0];
               rsp_ff.windup_held <= held_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire
